### hw/rtl/lz_stream_decompressor_core_macros.svh
// Assertion macros used by the decompressor controller.
// Depends on nothing; include it by bare file name inside a module body.
`ifndef LZ_STREAM_DECOMPRESSOR_CORE_MACROS_SVH
`define LZ_STREAM_DECOMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/lzsd_pkg.sv
// Shared types and constants of the LZ stream decompressor.
// Used by the controller, the datapath and the top level; depends on nothing.
package lzsd_pkg;

  // History store and window geometry.
  localparam int unsigned HIST_AW          = 16;
  localparam int unsigned HIST_DEPTH       = 65536;
  localparam int unsigned WINDOW_DEPTH_DEF = 65536;
  localparam int unsigned DATA_W           = 8;

  // Stream format constants.
  localparam logic [2:0] HDR_MAX      = 3'd4;
  localparam logic [5:0] LIT_LONG_MIN = 6'd60;
  localparam logic [5:0] LIT_LONG_OFS = 6'd59;
  localparam logic [6:0] COPY1_BASE   = 7'd4;

  // Tag type codes in the two low bits of a tag byte.
  localparam logic [1:0] TAG_LITERAL = 2'd0;
  localparam logic [1:0] TAG_COPY1   = 2'd1;
  localparam logic [1:0] TAG_COPY2   = 2'd2;
  localparam logic [1:0] TAG_INVALID = 2'd3;

  // Controller states: parse phases plus the two copy steps and the halt.
  typedef enum logic [3:0] {
    ST_HDR,
    ST_TAG,
    ST_LITLEN,
    ST_LITDATA,
    ST_OFF1,
    ST_OFF2LO,
    ST_OFF2HI,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_HALT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic hdr_step;
    logic tag_load;
    logic litlen_step;
    logic lit_emit;
    logic off1_load;
    logic off2lo_load;
    logic off2hi_load;
    logic err_emit;
    logic copy_rd;
    logic copy_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       frame_start;
    logic [1:0] tag_type;
    logic       tag_long;
    logic       hdr_done;
    logic       litlen_done;
    logic       lit_done;
    logic       off1_bad;
    logic       off2_bad;
    logic       out_free;
    logic       copy_last;
  } status_t;

endpackage

### hw/rtl/lz_stream_decompressor_core.sv
// Top level of the LZ stream decompressor: stream ports around the
// controller and the datapath. Depends on lzsd_pkg, lzsd_ctrl, lzsd_datapath.
//
// Takes one compressed byte per input transfer and returns decompressed bytes
// on the output stream. Header, length and offset bytes are taken one per
// cycle while the output register has room, and give no result; a literal
// byte gives one output transfer. A copy takes its last offset byte, then for
// each copied byte does one registered read of the history RAM and then
// writes the byte back and loads the output register, so the input is held
// off for the whole copy; this read-then-write loop lets overlapping copies
// repeat their pattern. A stall on the output stream stops the block until
// the waiting result is taken. An invalid tag or a bad offset gives one
// error transfer (byte zero, tlast and tuser high), after which bytes are
// consumed silently until a frame start. The history RAM needs no clearing
// pass after reset.
module lz_stream_decompressor_core #(
  parameter int unsigned WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] error
);
  import lzsd_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // Parser and copy sequencing.
  lzsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Registers, history RAM and output register.
  lzsd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_byte_i     (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .out_err_o     (m_axis_tuser)
  );

endmodule

### hw/rtl/lzsd_datapath.sv
// Datapath of the LZ stream decompressor: parser registers, history RAM
// and the output register. Depends on lzsd_pkg; driven by lzsd_ctrl.
module lzsd_datapath #(
  parameter int unsigned WINDOW_DEPTH = lzsd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lzsd_pkg::cmd_t       cmd_i,
  output lzsd_pkg::status_t    sts_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 out_err_o
);
  import lzsd_pkg::*;

  localparam int unsigned BW_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [BW_W-1:0] BW_MAX = BW_W'(WINDOW_DEPTH);

  // History RAM, undefined until written.
  logic [DATA_W-1:0] hist_mem [HIST_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [BW_W-1:0]    bw_q, bw_d;
  logic [2:0]         hc_q, hc_d;
  logic [32:0]        lr_q, lr_d;
  logic [2:0]         ebl_q, ebl_d;
  logic [6:0]         cl_q, cl_d;
  logic [15:0]        co_q, co_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q;
  logic               out_last_q, out_err_q;

  logic [5:0]         t6;
  logic [2:0]         hc_hdr;
  logic [2:0]         ebl_dec;
  logic [32:0]        lr_dec, lr_or;
  logic [15:0]        off1, off2;
  logic [HIST_AW-1:0] rd_addr;
  logic               mem_we;
  logic [DATA_W-1:0]  mem_wdata;
  logic               emit;

  // Decode of the incoming byte against the current register values.
  always_comb begin
    t6      = in_byte_i[7:2];
    hc_hdr  = (frame_start_i ? 3'd0 : hc_q) + 3'd1;
    ebl_dec = (ebl_q != 3'd0) ? ebl_q - 3'd1 : 3'd0;
    lr_dec  = (lr_q != 33'd0) ? lr_q - 33'd1 : 33'd0;
    lr_or   = lr_q | (33'(in_byte_i) << {hc_q[1:0], 3'b000});
    off1    = {5'd0, co_q[10:8], in_byte_i};
    off2    = {in_byte_i, co_q[7:0]};
    rd_addr = wp_q - co_q;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.frame_start = frame_start_i;
    sts_o.tag_type    = in_byte_i[1:0];
    sts_o.tag_long    = t6 >= LIT_LONG_MIN;
    sts_o.hdr_done    = !in_byte_i[7] || (hc_hdr >= HDR_MAX);
    sts_o.litlen_done = ebl_dec == 3'd0;
    sts_o.lit_done    = lr_dec == 33'd0;
    sts_o.off1_bad    = (off1 == 16'd0) || (32'(off1) > 32'(bw_q));
    sts_o.off2_bad    = (off2 == 16'd0) || (32'(off2) > 32'(bw_q));
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.copy_last   = cl_q == 7'd1;
  end

  // History write port: literal bytes and copied bytes.
  assign mem_we    = cmd_i.lit_emit || cmd_i.copy_wr;
  assign mem_wdata = cmd_i.lit_emit ? in_byte_i : rd_data_q;
  assign emit      = cmd_i.lit_emit || cmd_i.copy_wr || cmd_i.err_emit;

  // Next values of the parser registers.
  always_comb begin
    wp_d  = wp_q;
    bw_d  = bw_q;
    hc_d  = hc_q;
    lr_d  = lr_q;
    ebl_d = ebl_q;
    cl_d  = cl_q;
    co_d  = co_q;
    if (cmd_i.clear) begin
      wp_d  = '0;
      bw_d  = '0;
      lr_d  = '0;
      ebl_d = '0;
      cl_d  = '0;
      co_d  = '0;
    end
    if (cmd_i.hdr_step) begin
      hc_d = hc_hdr;
    end
    if (cmd_i.tag_load) begin
      case (in_byte_i[1:0])
        TAG_LITERAL: begin
          if (t6 < LIT_LONG_MIN) begin
            lr_d = 33'(t6) + 33'd1;
          end else begin
            ebl_d = 3'(t6 - LIT_LONG_OFS);
            hc_d  = '0;
            lr_d  = '0;
          end
        end
        TAG_COPY1: begin
          cl_d = 7'(t6[2:0]) + COPY1_BASE;
          co_d = {5'd0, in_byte_i[7:5], 8'd0};
        end
        TAG_COPY2: begin
          cl_d = 7'(t6) + 7'd1;
          co_d = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.litlen_step) begin
      hc_d  = hc_q + 3'd1;
      ebl_d = ebl_dec;
      lr_d  = (ebl_dec == 3'd0) ? ({1'b0, lr_or[31:0]} + 33'd1) : lr_or;
    end
    if (cmd_i.lit_emit) begin
      lr_d = lr_dec;
    end
    if (cmd_i.off1_load) begin
      co_d = off1;
    end
    if (cmd_i.off2lo_load) begin
      co_d = {8'd0, in_byte_i};
    end
    if (cmd_i.off2hi_load) begin
      co_d = off2;
    end
    if (cmd_i.copy_wr) begin
      cl_d = cl_q - 7'd1;
    end
    if (mem_we) begin
      wp_d = wp_q + HIST_AW'(1);
      if (bw_q != BW_MAX) begin
        bw_d = bw_q + BW_W'(1);
      end
    end
  end

  // Output register holds one result until its transfer.
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      bw_q        <= '0;
      hc_q        <= '0;
      lr_q        <= '0;
      ebl_q       <= '0;
      cl_q        <= '0;
      co_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      bw_q        <= bw_d;
      hc_q        <= hc_d;
      lr_q        <= lr_d;
      ebl_q       <= ebl_d;
      cl_q        <= cl_d;
      co_q        <= co_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; an error result carries a zero byte.
  always_ff @(posedge clk_i) begin
    if (cmd_i.err_emit) begin
      out_byte_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end else if (cmd_i.lit_emit) begin
      out_byte_q <= in_byte_i;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b0;
    end else if (cmd_i.copy_wr) begin
      out_byte_q <= rd_data_q;
      out_last_q <= cl_q == 7'd1;
      out_err_q  <= 1'b0;
    end
  end

  // History RAM with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= mem_wdata;
    end
    if (cmd_i.copy_rd) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

endmodule

### hw/rtl/lzsd_ctrl.sv
// Controller state machine of the LZ stream decompressor.
// Depends on lzsd_pkg and the assertion macro header; commands lzsd_datapath.
module lzsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lzsd_pkg::status_t sts_i,
  output lzsd_pkg::cmd_t    cmd_o
);
  import lzsd_pkg::*;
  `include "lz_stream_decompressor_core_macros.svh"

  state_e state_q, state_d;
  logic   accept_state;
  logic   accepted;

  // Input is taken in every parse state once the output register has room.
  assign accept_state = (state_q != ST_COPY_RD) && (state_q != ST_COPY_WR);
  assign in_ready_o   = accept_state && sts_i.out_free;
  assign accepted     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    if (accepted && sts_i.frame_start) begin
      state_d = sts_i.hdr_done ? ST_TAG : ST_HDR;
    end else begin
      case (state_q)
        ST_HDR: begin
          if (accepted && sts_i.hdr_done) state_d = ST_TAG;
        end
        ST_TAG: begin
          if (accepted) begin
            case (sts_i.tag_type)
              TAG_LITERAL: state_d = sts_i.tag_long ? ST_LITLEN : ST_LITDATA;
              TAG_COPY1:   state_d = ST_OFF1;
              TAG_COPY2:   state_d = ST_OFF2LO;
              default:     state_d = ST_HALT;
            endcase
          end
        end
        ST_LITLEN: begin
          if (accepted && sts_i.litlen_done) state_d = ST_LITDATA;
        end
        ST_LITDATA: begin
          if (accepted && sts_i.lit_done) state_d = ST_TAG;
        end
        ST_OFF1: begin
          if (accepted) state_d = sts_i.off1_bad ? ST_HALT : ST_COPY_RD;
        end
        ST_OFF2LO: begin
          if (accepted) state_d = ST_OFF2HI;
        end
        ST_OFF2HI: begin
          if (accepted) state_d = sts_i.off2_bad ? ST_HALT : ST_COPY_RD;
        end
        ST_COPY_RD: begin
          state_d = ST_COPY_WR;
        end
        ST_COPY_WR: begin
          if (sts_i.out_free) state_d = sts_i.copy_last ? ST_TAG : ST_COPY_RD;
        end
        ST_HALT: begin
          state_d = ST_HALT;
        end
        default: begin
          state_d = ST_TAG;
        end
      endcase
    end
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    if (accepted && sts_i.frame_start) begin
      cmd_o.clear    = 1'b1;
      cmd_o.hdr_step = 1'b1;
    end else begin
      case (state_q)
        ST_HDR:     cmd_o.hdr_step = accepted;
        ST_TAG: begin
          cmd_o.tag_load = accepted;
          cmd_o.err_emit = accepted && (sts_i.tag_type == TAG_INVALID);
        end
        ST_LITLEN:  cmd_o.litlen_step = accepted;
        ST_LITDATA: cmd_o.lit_emit = accepted;
        ST_OFF1: begin
          cmd_o.off1_load = accepted;
          cmd_o.err_emit  = accepted && sts_i.off1_bad;
        end
        ST_OFF2LO:  cmd_o.off2lo_load = accepted;
        ST_OFF2HI: begin
          cmd_o.off2hi_load = accepted;
          cmd_o.err_emit    = accepted && sts_i.off2_bad;
        end
        ST_COPY_RD: cmd_o.copy_rd = 1'b1;
        ST_COPY_WR: cmd_o.copy_wr = sts_i.out_free;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HDR;
    end else begin
      state_q <= state_d;
    end
  end

  // Input stays blocked for the whole of a copy.
  `LZSD_ASSERT_IMPL(a_copy_blocks_input, clk_i, rst_ni, !accept_state, !in_ready_o)
  // Every history read is followed by its write-back step.
  `LZSD_ASSERT_NEXT(a_read_then_write, clk_i, rst_ni, state_q == ST_COPY_RD,
                    state_q == ST_COPY_WR)
  // An error result always halts the stream.
  `LZSD_ASSERT_NEXT(a_error_halts, clk_i, rst_ni, cmd_o.err_emit, state_q == ST_HALT)

endmodule
